@@ src/bps_pkg.sv @@
// Package for the bilinear pixel sampler: field structs, sizes, fixed-point
// constants, register indexes and sequencer states. No dependencies.
package bps_pkg;

  localparam int MAX_WIDTH    = 64;
  localparam int MAX_HEIGHT   = 64;
  localparam int MAX_CHANNELS = 4;
  localparam int FRAC_BITS    = 8;

  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int CH_W    = 2;
  localparam int ADDR_W  = ROW_W + COL_W + CH_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;

  localparam int PIX_W   = 8;
  localparam int COORD_W = 16;
  localparam int XI_W    = COORD_W - 1 - FRAC_BITS;
  localparam int DIM_W   = 7;
  localparam int CCNT_W  = 3;
  localparam int VAL_W   = 16;

  localparam int FW         = FRAC_BITS + 1;
  localparam int WGT_W      = 2 * FRAC_BITS + 1;
  localparam int PROD_W     = PIX_W + WGT_W;
  localparam int ACC_W      = PIX_W + 2 * FRAC_BITS + 2;
  localparam int RND_SHIFT  = 2 * FRAC_BITS - 8;
  localparam int ROUND_INC  = (RND_SHIFT > 0) ? (1 << (RND_SHIFT - 1)) : 0;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH   = 2'd0,
    REG_IMAGE_HEIGHT  = 2'd1,
    REG_CHANNEL_COUNT = 2'd2
  } bps_reg_e;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } bps_op_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } bps_state_e;

  typedef struct packed {
    logic                      operation;
    logic [5:0]                write_row;
    logic [5:0]                write_column;
    logic [1:0]                write_channel;
    logic [7:0]                write_value;
    logic signed [COORD_W-1:0] sample_x;
    logic signed [COORD_W-1:0] sample_y;
  } bps_req_t;

  typedef struct packed {
    logic [1:0]       channel_index;
    logic [VAL_W-1:0] sample_value;
    logic             in_bounds;
    logic             last_channel;
  } bps_res_t;

  // One tap step issued by the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic            valid;
    logic [1:0]      tap;
    logic [CH_W-1:0] chan;
    logic            last;
    logic            inb;
  } bps_step_t;

  // Weight load request, given with the fraction parts of a sample.
  typedef struct packed {
    logic                 load;
    logic [FRAC_BITS-1:0] fx;
    logic [FRAC_BITS-1:0] fy;
  } bps_wload_t;

endpackage

@@ src/bps_pixel_mem.sv @@
// Single-port pixel byte store with registered read data.
// Depends on bps_pkg for depth and widths.
module bps_pixel_mem (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [bps_pkg::ADDR_W-1:0]  addr_i,
  input  logic [bps_pkg::PIX_W-1:0]   wdata_i,
  output logic [bps_pkg::PIX_W-1:0]   rdata_o
);

  logic [bps_pkg::PIX_W-1:0] mem [bps_pkg::MEM_DEPTH];
  logic [bps_pkg::PIX_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/bps_mac.sv @@
// Shared multiply-accumulate unit: tap weights, accumulator, rounding and
// the result register. Depends on bps_pkg.
module bps_mac (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bps_pkg::bps_wload_t       wload_i,
  input  bps_pkg::bps_step_t        step_i,
  input  logic [bps_pkg::PIX_W-1:0] pix_i,
  output logic                      pipe_busy_o,
  output logic                      result_valid_o,
  output bps_pkg::bps_res_t         res_o
);

  logic [bps_pkg::WGT_W-1:0]  w_q [4];
  logic [bps_pkg::WGT_W-1:0]  w_d [4];
  logic [bps_pkg::FW-1:0]     wx [2];
  logic [bps_pkg::FW-1:0]     wy [2];
  bps_pkg::bps_step_t         s1_q, s2_q, s2_d;
  logic [bps_pkg::ACC_W-1:0]  acc_q, acc_d;
  logic [bps_pkg::PROD_W-1:0] prod;
  logic [bps_pkg::ACC_W-1:0]  rsum;
  logic                       valid_q;
  bps_pkg::bps_res_t          res_q, res_d;

  always_comb begin
    wx[0] = bps_pkg::FW'(1 << bps_pkg::FRAC_BITS) - {1'b0, wload_i.fx};
    wx[1] = {1'b0, wload_i.fx};
    wy[0] = bps_pkg::FW'(1 << bps_pkg::FRAC_BITS) - {1'b0, wload_i.fy};
    wy[1] = {1'b0, wload_i.fy};
    for (int t = 0; t < 4; t++) begin
      w_d[t] = bps_pkg::WGT_W'(wx[t % 2] * wy[t / 2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wload_i.load) begin
      w_q <= w_d;
    end
  end

  // Tap zero starts a fresh sum, so no clear cycle is needed between channels.
  always_comb begin
    prod  = bps_pkg::PROD_W'(pix_i * w_q[s1_q.tap]);
    acc_d = ((s1_q.tap == 2'd0) ? '0 : acc_q) + bps_pkg::ACC_W'(prod);
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  always_comb begin
    s2_d       = s1_q;
    s2_d.valid = s1_q.valid && (s1_q.tap == 2'd3);
  end

  always_comb begin
    rsum = acc_q + bps_pkg::ACC_W'(bps_pkg::ROUND_INC);
    res_d.channel_index = s2_q.chan;
    res_d.sample_value  = s2_q.inb ? bps_pkg::VAL_W'(rsum >> bps_pkg::RND_SHIFT) : '0;
    res_d.in_bounds     = s2_q.inb;
    res_d.last_channel  = s2_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q    <= '0;
      s2_q    <= '0;
      valid_q <= 1'b0;
    end else begin
      s1_q    <= step_i;
      s2_q    <= s2_d;
      valid_q <= s2_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_q.valid) begin
      res_q <= res_d;
    end
  end

  assign pipe_busy_o    = s1_q.valid || s2_q.valid;
  assign result_valid_o = valid_q;
  assign res_o          = res_q;

endmodule

@@ src/bps_ctrl.sv @@
// Sequencer: configuration registers, bounds test, and the per-channel tap
// walk that drives the pixel store and the MAC unit. Depends on bps_pkg.
module bps_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  input  bps_pkg::bps_req_t            req_i,
  input  logic                         pipe_busy_i,
  output logic                         busy,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [1:0]                   cfg_index_i,
  input  logic [bps_pkg::DIM_W-1:0]    cfg_data_i,
  output logic                         mem_we_o,
  output logic [bps_pkg::ADDR_W-1:0]   mem_addr_o,
  output logic [bps_pkg::PIX_W-1:0]    mem_wdata_o,
  output bps_pkg::bps_wload_t          wload_o,
  output bps_pkg::bps_step_t           step_o
);

  bps_pkg::bps_state_e state_q, state_d;

  logic [bps_pkg::DIM_W-1:0]  width_q, height_q;
  logic [bps_pkg::CCNT_W-1:0] ccnt_q;
  logic [bps_pkg::COL_W-1:0]  xi_q, xi_d;
  logic [bps_pkg::ROW_W-1:0]  yi_q, yi_d;
  logic                       inb_q, inb_d;
  logic [bps_pkg::CH_W-1:0]   nch_m1_q, nch_m1_d;
  logic [bps_pkg::CH_W-1:0]   chan_q, chan_d;
  logic [1:0]                 tap_q, tap_d;

  logic                       accept;
  logic [bps_pkg::XI_W-1:0]   xi_full, yi_full;
  logic [bps_pkg::DIM_W-1:0]  w_sat, h_sat;
  logic [bps_pkg::ROW_W-1:0]  rd_row;
  logic [bps_pkg::COL_W-1:0]  rd_col;
  logic                       last_tap;

  assign busy        = (state_q != bps_pkg::ST_IDLE) || pipe_busy_i;
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bps_pkg::DIM_W'(bps_pkg::MAX_WIDTH);
      height_q <= bps_pkg::DIM_W'(bps_pkg::MAX_HEIGHT);
      ccnt_q   <= bps_pkg::CCNT_W'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bps_pkg::REG_IMAGE_WIDTH:   width_q  <= cfg_data_i;
        bps_pkg::REG_IMAGE_HEIGHT:  height_q <= cfg_data_i;
        bps_pkg::REG_CHANNEL_COUNT: ccnt_q   <= cfg_data_i[bps_pkg::CCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Bounds and channel count are settled once, when a sample is taken.
  always_comb begin
    w_sat   = (width_q > bps_pkg::DIM_W'(bps_pkg::MAX_WIDTH)) ?
              bps_pkg::DIM_W'(bps_pkg::MAX_WIDTH) : width_q;
    h_sat   = (height_q > bps_pkg::DIM_W'(bps_pkg::MAX_HEIGHT)) ?
              bps_pkg::DIM_W'(bps_pkg::MAX_HEIGHT) : height_q;
    xi_full = req_i.sample_x[bps_pkg::COORD_W-2:bps_pkg::FRAC_BITS];
    yi_full = req_i.sample_y[bps_pkg::COORD_W-2:bps_pkg::FRAC_BITS];
    inb_d   = !req_i.sample_x[bps_pkg::COORD_W-1] && !req_i.sample_y[bps_pkg::COORD_W-1] &&
              ({1'b0, xi_full} + 8'd1 < {1'b0, w_sat}) &&
              ({1'b0, yi_full} + 8'd1 < {1'b0, h_sat});
    if (ccnt_q == '0) begin
      nch_m1_d = '0;
    end else if (ccnt_q > bps_pkg::CCNT_W'(bps_pkg::MAX_CHANNELS)) begin
      nch_m1_d = bps_pkg::CH_W'(bps_pkg::MAX_CHANNELS - 1);
    end else begin
      nch_m1_d = bps_pkg::CH_W'(ccnt_q - 3'd1);
    end
  end

  assign last_tap = (tap_q == 2'd3);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      bps_pkg::ST_IDLE: begin
        if (accept && req_i.operation == bps_pkg::OP_SAMPLE) begin
          state_d = bps_pkg::ST_RUN;
        end
      end
      bps_pkg::ST_RUN: begin
        if (last_tap && chan_q == nch_m1_q) begin
          state_d = bps_pkg::ST_IDLE;
        end
      end
      default: state_d = bps_pkg::ST_IDLE;
    endcase
  end

  // Tap walk: four taps per channel in bounds, a single step per channel otherwise.
  always_comb begin
    xi_d = xi_q;
    yi_d = yi_q;
    chan_d = chan_q;
    tap_d = tap_q;
    if (state_q == bps_pkg::ST_IDLE) begin
      xi_d   = xi_full[bps_pkg::COL_W-1:0];
      yi_d   = yi_full[bps_pkg::ROW_W-1:0];
      chan_d = '0;
      tap_d  = inb_d ? 2'd0 : 2'd3;
    end else if (last_tap) begin
      chan_d = chan_q + 1'b1;
      tap_d  = inb_q ? 2'd0 : 2'd3;
    end else begin
      tap_d = tap_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bps_pkg::ST_IDLE;
      chan_q  <= '0;
      tap_q   <= '0;
      inb_q   <= 1'b0;
      nch_m1_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == bps_pkg::ST_RUN || accept) begin
        chan_q <= chan_d;
        tap_q  <= tap_d;
      end
      if (accept) begin
        inb_q    <= inb_d;
        nch_m1_q <= nch_m1_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      xi_q <= xi_d;
      yi_q <= yi_d;
    end
  end

  // Outputs.
  always_comb begin
    rd_row       = yi_q + bps_pkg::ROW_W'(tap_q[1]);
    rd_col       = xi_q + bps_pkg::COL_W'(tap_q[0]);
    mem_we_o     = accept && (req_i.operation == bps_pkg::OP_WRITE);
    mem_wdata_o  = req_i.write_value;
    if (state_q == bps_pkg::ST_IDLE) begin
      mem_addr_o = {req_i.write_row, req_i.write_column, req_i.write_channel};
    end else begin
      mem_addr_o = {rd_row, rd_col, chan_q};
    end
    wload_o.load = accept && (req_i.operation == bps_pkg::OP_SAMPLE);
    wload_o.fx   = req_i.sample_x[bps_pkg::FRAC_BITS-1:0];
    wload_o.fy   = req_i.sample_y[bps_pkg::FRAC_BITS-1:0];
    step_o.valid = (state_q == bps_pkg::ST_RUN);
    step_o.tap   = tap_q;
    step_o.chan  = chan_q;
    step_o.last  = (chan_q == nch_m1_q);
    step_o.inb   = inb_q;
  end

endmodule

@@ src/bilinear_pixel_sampler_unit.sv @@
// Bilinear pixel sampler: a pixel write gives no result.
// A sample in bounds reads four taps per channel, one per cycle, through one store
// port and one multiply-accumulate unit; a result follows each channel, and the next
// item is taken only once the tap walk and the MAC pipeline are done.
// Out of bounds: one result per cycle, one per channel; the next item waits likewise.
// Results cannot be stalled. Reset (rst_ni, async) restores 64x64, one channel only.
module bilinear_pixel_sampler_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  bps_pkg::bps_req_t            req_i,
  output logic                         result_valid_o,
  output bps_pkg::bps_res_t            res_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [1:0]                   cfg_index_i,
  input  logic [bps_pkg::DIM_W-1:0]    cfg_data_i
);

  logic                        mem_we;
  logic [bps_pkg::ADDR_W-1:0]  mem_addr;
  logic [bps_pkg::PIX_W-1:0]   mem_wdata, mem_rdata;
  bps_pkg::bps_wload_t         wload;
  bps_pkg::bps_step_t          step;
  logic                        pipe_busy;

  bps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .req_i       (req_i),
    .pipe_busy_i (pipe_busy),
    .busy        (busy),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .mem_we_o    (mem_we),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .wload_o     (wload),
    .step_o      (step)
  );

  bps_pixel_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  bps_mac u_mac (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .wload_i        (wload),
    .step_i         (step),
    .pix_i          (mem_rdata),
    .pipe_busy_o    (pipe_busy),
    .result_valid_o (result_valid_o),
    .res_o          (res_o)
  );

endmodule

@@ src/bps_checker.sv @@
// Port-level checks for the bilinear pixel sampler, bound to the top level.
// Depends on bps_pkg and bilinear_pixel_sampler_unit.
module bps_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input bps_pkg::bps_req_t req_i,
  input logic              result_valid_o,
  input bps_pkg::bps_res_t res_o
);

  // An out-of-bounds item always carries a zero value.
  a_oob_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !res_o.in_bounds |-> res_o.sample_value == '0)
    else $error("out-of-bounds result with nonzero value");

  // A sample keeps the block busy; a pixel write completes at once.
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && req_i.operation == bps_pkg::OP_SAMPLE |=> busy)
    else $error("sample accepted without going busy");

  a_write_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && req_i.operation == bps_pkg::OP_WRITE |=> !busy && !result_valid_o)
    else $error("pixel write caused activity");

  // The final item of a sample is never directly followed by another item.
  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && res_o.last_channel |=> !result_valid_o)
    else $error("result right after last channel");

endmodule

bind bilinear_pixel_sampler_unit bps_checker u_bps_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .req_i          (req_i),
  .result_valid_o (result_valid_o),
  .res_o          (res_o)
);

@@ verif/testbench.sv @@
// Self-checking testbench for bilinear_pixel_sampler_unit: loads pixels, samples them
// under several image sizes and channel counts, and checks each result in order.
// Depends on bps_pkg (src/bps_pkg.sv) and the sampler RTL; needs no other files.
module testbench;
  import bps_pkg::*;

  localparam int DRAIN_CYCLES    = 4 * MAX_CHANNELS + 8;
  localparam int STALL_LIMIT     = 1000;
  localparam int ITEMS_PER_PHASE = 27;
  localparam int SCALE_SHIFT     = 2 * FRAC_BITS - 8;
  localparam int UNIT_WEIGHT     = 1 << FRAC_BITS;

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  bps_req_t                req;
  logic                    res_valid;
  bps_res_t                res;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [1:0]              cfg_index;
  logic [DIM_W-1:0]        cfg_data;

  class sampler_scoreboard;
    logic [PIX_W-1:0] pixel_mem [MEM_DEPTH];
    bit               written [MEM_DEPTH];
    int unsigned      width_reg;
    int unsigned      height_reg;
    int unsigned      chan_reg;
    bps_res_t         pending_results [$];
    int unsigned      errors;

    function new();
      width_reg   = 64;
      height_reg  = 64;
      chan_reg    = 1;
      errors      = 0;
    endfunction

    function int unsigned addr_of(int unsigned row, int unsigned col, int unsigned ch);
      return (row * MAX_WIDTH + col) * MAX_CHANNELS + ch;
    endfunction

    function void set_register(bps_reg_e idx, logic [DIM_W-1:0] data);
      case (idx)
        REG_IMAGE_WIDTH:   width_reg = data;
        REG_IMAGE_HEIGHT:  height_reg = data;
        REG_CHANNEL_COUNT: chan_reg = data[CCNT_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_width();
      return (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    endfunction

    function int unsigned eff_height();
      return (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
    endfunction

    function int unsigned active_channels();
      int unsigned n;
      n = (chan_reg == 0) ? 1 : chan_reg;
      return (n > MAX_CHANNELS) ? MAX_CHANNELS : n;
    endfunction

    // Integer parts come from a floor, so a negative coordinate is always outside.
    function bit lands_inside(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                              output int unsigned col, output int unsigned row);
      int xs;
      int ys;
      xs  = x;
      ys  = y;
      col = 0;
      row = 0;
      if (xs < 0 || ys < 0) return 0;
      col = xs >> FRAC_BITS;
      row = ys >> FRAC_BITS;
      return (col + 1 < eff_width()) && (row + 1 < eff_height());
    endfunction

    function longint unsigned pixel_at(int unsigned row, int unsigned col, int unsigned ch);
      return pixel_mem[addr_of(row, col, ch)];
    endfunction

    function void note_item(bps_req_t item);
      int unsigned       col;
      int unsigned       row;
      int unsigned       fx;
      int unsigned       fy;
      int unsigned       nch;
      int unsigned       c;
      longint unsigned   wx0;
      longint unsigned   wy0;
      longint unsigned   acc;
      longint unsigned   val;
      bit                inb;
      bps_res_t          r;
      if (item.operation == OP_WRITE) begin
        pixel_mem[addr_of(item.write_row, item.write_column, item.write_channel)] =
          item.write_value;
        written[addr_of(item.write_row, item.write_column, item.write_channel)] = 1'b1;
        return;
      end
      inb = lands_inside(item.sample_x, item.sample_y, col, row);
      fx  = item.sample_x[FRAC_BITS-1:0];
      fy  = item.sample_y[FRAC_BITS-1:0];
      wx0 = UNIT_WEIGHT - fx;
      wy0 = UNIT_WEIGHT - fy;
      nch = active_channels();
      for (c = 0; c < nch; c++) begin
        val = 0;
        if (inb) begin
          acc = pixel_at(row, col, c) * wx0 * wy0
              + pixel_at(row, col + 1, c) * fx * wy0
              + pixel_at(row + 1, col, c) * wx0 * fy
              + pixel_at(row + 1, col + 1, c) * fx * fy;
          val = (SCALE_SHIFT > 0) ? ((acc + (64'd1 << (SCALE_SHIFT - 1))) >> SCALE_SHIFT)
                                  : acc;
        end
        r.channel_index = 2'(c);
        r.sample_value  = val[VAL_W-1:0];
        r.in_bounds     = inb;
        r.last_channel  = (c + 1 == nch);
        pending_results.push_back(r);
      end
    endfunction

    function void check_result(bps_res_t got);
      bps_res_t want;
      if (pending_results.size() == 0) begin
        $error("result with no sample pending: channel_index %0d sample_value %0d",
               got.channel_index, got.sample_value);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.channel_index !== want.channel_index) begin
        $error("channel_index: expected %0d, actual %0d", want.channel_index,
               got.channel_index);
        errors++;
      end
      if (got.sample_value !== want.sample_value) begin
        $error("sample_value: expected %0d, actual %0d", want.sample_value,
               got.sample_value);
        errors++;
      end
      if (got.in_bounds !== want.in_bounds) begin
        $error("in_bounds: expected %0d, actual %0d", want.in_bounds, got.in_bounds);
        errors++;
      end
      if (got.last_channel !== want.last_channel) begin
        $error("last_channel: expected %0d, actual %0d", want.last_channel,
               got.last_channel);
        errors++;
      end
    endfunction
  endclass

  sampler_scoreboard sb;
  int unsigned       idle_pct;
  int unsigned       item_count;
  int unsigned       stall_count;

  bilinear_pixel_sampler_unit DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start          (start),
    .busy           (busy),
    .req_i          (req),
    .result_valid_o (res_valid),
    .res_o          (res),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && res_valid) sb.check_result(res);
  end

  // Ends the run when nothing moves on any channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || res_valid || (cfg_valid && cfg_ready)) begin
      stall_count <= 0;
    end else if (stall_count == STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  function automatic bps_req_t random_request();
    bps_req_t item;
    item.operation     = OP_WRITE;
    item.write_row     = 6'($urandom_range(0, 63));
    item.write_column  = 6'($urandom_range(0, 63));
    item.write_channel = 2'($urandom_range(0, 3));
    item.write_value   = 8'($urandom_range(0, 255));
    item.sample_x      = 16'($urandom);
    item.sample_y      = 16'($urandom);
    return item;
  endfunction

  task automatic drive_item(input bps_req_t item);
    @(negedge clk);
    if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    start = 1'b1;
    req   = item;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(item);
    item_count++;
  endtask

  task automatic put_pixel(input int unsigned row, input int unsigned col,
                           input int unsigned ch, input int unsigned value);
    bps_req_t item;
    item               = random_request();
    item.operation     = OP_WRITE;
    item.write_row     = 6'(row);
    item.write_column  = 6'(col);
    item.write_channel = 2'(ch);
    item.write_value   = 8'(value);
    drive_item(item);
  endtask

  // Any neighbor byte not yet loaded is written first, so no in-bounds sample reads an
  // uninitialized store entry.
  task automatic take_sample(input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y);
    int unsigned col;
    int unsigned row;
    int unsigned nch;
    int unsigned c;
    int unsigned dr;
    int unsigned dc;
    bps_req_t    item;
    if (sb.lands_inside(x, y, col, row)) begin
      nch = sb.active_channels();
      for (c = 0; c < nch; c++)
        for (dr = 0; dr < 2; dr++)
          for (dc = 0; dc < 2; dc++)
            if (!sb.written[sb.addr_of(row + dr, col + dc, c)])
              put_pixel(row + dr, col + dc, c, $urandom_range(0, 255));
    end
    item           = random_request();
    item.operation = OP_SAMPLE;
    item.sample_x  = x;
    item.sample_y  = y;
    drive_item(item);
  endtask

  task automatic write_register(input bps_reg_e idx, input int unsigned data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = DIM_W'(data);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_register(idx, DIM_W'(data));
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Waits for every expected result, then lets a trailing pixel write finish.
  task automatic settle();
    @(negedge clk);
    start = 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic apply_setting(input int unsigned w, input int unsigned h,
                               input int unsigned ch);
    settle();
    write_register(REG_IMAGE_WIDTH, w);
    write_register(REG_IMAGE_HEIGHT, h);
    write_register(REG_CHANNEL_COUNT, ch);
  endtask

  function automatic int unsigned pick_fraction();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return UNIT_WEIGHT - 1;
      default: return $urandom_range(0, UNIT_WEIGHT - 1);
    endcase
  endfunction

  // Cell index inside an image of n pixels; favors a small corner window so
  // the loaded neighborhoods get reused.
  function automatic int unsigned pick_cell(int unsigned n);
    int unsigned lim;
    lim = (n >= 2) ? n - 2 : 0;
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, lim);
      1:       return $urandom_range(0, 1) ? lim : 0;
      default: return $urandom_range(0, (lim < 3) ? lim : 3);
    endcase
  endfunction

  task automatic random_step();
    int unsigned          mode;
    int unsigned          col;
    int unsigned          row;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    mode = $urandom_range(0, 99);
    if (mode < 15) begin
      put_pixel($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 3),
                $urandom_range(0, 255));
      return;
    end
    col = pick_cell(sb.eff_width());
    row = pick_cell(sb.eff_height());
    if (mode < 35) begin
      // Just past the right or bottom edge.
      if ($urandom_range(0, 1))
        col = (sb.eff_width() > 0) ? sb.eff_width() - 1 : 0;
      else
        row = (sb.eff_height() > 0) ? sb.eff_height() - 1 : 0;
    end
    if (mode < 85) begin
      x = COORD_W'((col << FRAC_BITS) + pick_fraction());
      y = COORD_W'((row << FRAC_BITS) + pick_fraction());
    end else begin
      x = COORD_W'($urandom);
      y = COORD_W'($urandom);
    end
    take_sample(x, y);
  endtask

  task automatic run_phase(input int unsigned phase);
    while (item_count < 21 + (phase + 1) * ITEMS_PER_PHASE)
      random_step();
  endtask

  initial begin
    sb         = new();
    clk        = 1'b0;
    rst_n      = 1'b0;
    start      = 1'b0;
    req        = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    idle_pct   = 20;
    item_count = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Directed part at the reset size of 64x64 with one channel.
    put_pixel(0, 0, 0, 0);
    put_pixel(0, 1, 0, 255);
    put_pixel(1, 0, 0, 128);
    put_pixel(1, 1, 0, 77);
    put_pixel(62, 62, 0, 255);
    put_pixel(62, 63, 0, 255);
    put_pixel(63, 62, 0, 255);
    put_pixel(63, 63, 0, 255);
    put_pixel(63, 63, 3, 200);
    put_pixel(5, 5, 3, 0);
    take_sample(16'sh0000, 16'sh0000);
    take_sample(16'sh00FF, 16'sh00FF);
    take_sample(16'sh0080, 16'sh0001);
    take_sample(16'sh3E80, 16'sh3EFF);
    take_sample(16'sh3F00, 16'sh0000);
    take_sample(16'sh0000, 16'sh3F00);
    take_sample(-16'sd1, 16'sh0000);
    take_sample(16'sh7FFF, -16'sd32768);
    take_sample(-16'sd32768, 16'sh7FFF);

    apply_setting(64, 64, 4);
    idle_pct = 30;
    run_phase(0);
    apply_setting(2, 2, 2);
    idle_pct = 0;
    run_phase(1);
    apply_setting(127, 127, 7);
    idle_pct = 50;
    run_phase(2);
    // Width below two and a channel count of zero: every sample falls outside.
    apply_setting(0, 1, 0);
    idle_pct = 20;
    run_phase(3);
    apply_setting($urandom_range(2, 64), $urandom_range(2, 64), $urandom_range(1, 4));
    idle_pct = 30;
    run_phase(4);
    apply_setting($urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 127));
    idle_pct = 40;
    run_phase(5);
    apply_setting(64, 64, 3);
    idle_pct = 0;
    run_phase(6);

    settle();
    if (sb.errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end
endmodule

@@ bilinear_pixel_sampler_unit.f @@
src/bps_pkg.sv
src/bps_pixel_mem.sv
src/bps_mac.sv
src/bps_ctrl.sv
src/bilinear_pixel_sampler_unit.sv
src/bps_checker.sv
verif/testbench.sv
